// ----- sv/gsfp_pkg.sv -----
package gsfp_pkg;

  // Frame layout
  localparam int unsigned FRAME_BYTES = 9;
  localparam int unsigned POS_W       = 4;
  localparam logic [7:0]       START_BYTE = 8'hFF;
  localparam logic [POS_W-1:0] POS_CMD    = POS_W'(1);
  localparam logic [POS_W-1:0] POS_HIGH   = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LOW    = POS_W'(3);
  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_BYTES - 1);

  // Register indexes and reset values
  localparam logic REG_COMMAND_CODE   = 1'b0;
  localparam logic REG_NIBBLE_CONVERT = 1'b1;
  localparam logic [7:0] COMMAND_CODE_RST = 8'h86;

  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_CMD  = 3'b010,
    PH_DATA = 3'b100
  } gsfp_phase_t;

  typedef struct packed {
    logic [7:0] command_code;
    logic       nibble_convert;
  } gsfp_cfg_t;

  typedef struct packed {
    logic [15:0] concentration;
    logic        sum_match;
  } gsfp_res_t;

  // (v / 10) * 16 + (v % 10), modulo 256. The quotient comes from a multiply
  // by 205 / 2048, exact for all 8-bit values; only its low nibble survives.
  function automatic logic [7:0] tens_to_nibble(input logic [7:0] v);
    logic [15:0] prod;
    logic [4:0]  quo;
    logic [7:0]  rem;
    prod = 16'(v) * 16'd205;
    quo  = prod[15:11];
    rem  = v - (8'(quo) * 8'd10);
    return {quo[3:0], rem[3:0]};
  endfunction

endpackage

// ----- sv/gsfp_parser.sv -----
module gsfp_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  input  gsfp_pkg::gsfp_cfg_t cfg,
  output logic                res_valid,
  output gsfp_pkg::gsfp_res_t res
);
  import gsfp_pkg::*;

  gsfp_phase_t      phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       high_r, high_nxt;
  logic [7:0]       low_r, low_nxt;
  logic [7:0]       expect_sum;
  logic [7:0]       high_out;
  logic [7:0]       low_out;

  assign expect_sum = 8'd0 - sum_r;
  assign high_out   = cfg.nibble_convert ? tens_to_nibble(high_r) : high_r;
  assign low_out    = cfg.nibble_convert ? tens_to_nibble(low_r) : low_r;

  assign res.concentration = {high_out, low_out};
  assign res.sum_match     = (rx_byte == expect_sum);

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    high_nxt  = high_r;
    low_nxt   = low_r;
    res_valid = 1'b0;
    if (accept) begin
      unique case (phase_r)
        PH_CMD: begin
          if (rx_byte == cfg.command_code) begin
            phase_nxt = PH_DATA;
            sum_nxt   = rx_byte;
            pos_nxt   = POS_HIGH;
          end else begin
            phase_nxt = PH_HUNT;
            pos_nxt   = '0;
          end
        end
        PH_DATA: begin
          if (pos_r >= POS_LAST) begin
            // checksum byte: emit and go back to hunting
            res_valid = 1'b1;
            phase_nxt = PH_HUNT;
            pos_nxt   = '0;
          end else begin
            if (pos_r == POS_HIGH) high_nxt = rx_byte;
            if (pos_r == POS_LOW)  low_nxt  = rx_byte;
            sum_nxt = sum_r + rx_byte;
            pos_nxt = pos_r + POS_W'(1);
          end
        end
        default: begin
          if (rx_byte == START_BYTE) begin
            phase_nxt = PH_CMD;
            pos_nxt   = POS_CMD;
            sum_nxt   = '0;
          end else begin
            phase_nxt = PH_HUNT;
            pos_nxt   = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      pos_r   <= '0;
      sum_r   <= '0;
      high_r  <= '0;
      low_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
      high_r  <= high_nxt;
      low_r   <= low_nxt;
    end
  end

endmodule

// ----- sv/gas_sensor_frame_parser_unit.sv -----
// Nine-byte gas sensor frame parser. Feed received serial bytes, one word per
// byte, on the in_ channel; the block takes one byte every cycle while in_stall
// is low. A frame is 0xFF, the command byte set in register 0 (reset 0x86), six
// data bytes and a checksum byte; bytes 2 and 3 form the concentration
// (high * 256 + low). When the checksum byte is taken, one result word is
// registered for out_, into the skid word if the result register is held,
// carrying the concentration and whether the checksum (two's complement of the
// 8-bit sum of bytes 1 to 7) matched; a bad checksum still yields a word. A
// wrong command byte drops the frame and that byte is not rechecked as a start
// byte. Register 1 bit 0 selects the tens-to-nibble conversion of the high and
// low bytes. The rate is set by the per-byte state update, one register stage
// deep; a two-word output stage (result register plus skid) keeps bytes flowing
// while a result waits, and in_stall rises only when both words are held. No
// clearing pass after reset; write registers only while idle.
module gas_sensor_frame_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_concentration,
  output logic        out_sum_match,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import gsfp_pkg::*;

  gsfp_cfg_t cfg_r, cfg_nxt;

  logic      in_take;
  logic      res_valid;
  gsfp_res_t res;

  // result register and skid word
  logic      out_valid_r, out_valid_nxt;
  gsfp_res_t out_data_r, out_data_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  gsfp_res_t skid_data_r, skid_data_nxt;
  logic      out_free;

  // Configuration: plain indexed write.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_COMMAND_CODE:   cfg_nxt.command_code   = cfg_wdata;
        REG_NIBBLE_CONVERT: cfg_nxt.nibble_convert = cfg_wdata[0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.command_code   <= COMMAND_CODE_RST;
      cfg_r.nibble_convert <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Accept a byte whenever the skid word is empty.
  assign in_stall = skid_valid_r;
  assign in_take  = in_valid && !in_stall;

  gsfp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_take),
    .rx_byte   (in_rx_byte),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output stage: the result register refills from the skid word first, then
  // from a fresh result; a fresh result that meets a held register goes to skid.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_free) begin
      out_valid_nxt  = skid_valid_r || res_valid;
      out_data_nxt   = skid_valid_r ? skid_data_r : res;
      skid_valid_nxt = 1'b0;
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload words carry no reset.
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_concentration = out_data_r.concentration;
  assign out_sum_match     = out_data_r.sum_match;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held while result register empty");

  a_no_result_into_full_skid: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !skid_valid_r)
    else $error("result produced while skid word occupied");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid word filled without a stalled result");

  a_skid_keeps_data: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && $past(skid_valid_r)) |-> $stable(skid_data_r))
    else $error("skid word changed while held");
`endif

endmodule

// ----- tb/sv/tb_gas_sensor_frame_parser_unit.sv -----
module tb_gas_sensor_frame_parser_unit;
  import gsfp_pkg::*;

  // Each side idles in about this many cycles of a hundred.
  localparam int unsigned IDLE_PCT        = 27;
  // A result word is registered after its checksum byte, or waits in the skid
  // word; let the block settle before touching a register or closing the run.
  localparam int unsigned SETTLE_CYCLES   = 4;
  // Give up after this many cycles in a row with no word moving on either
  // channel. The slowest correct run never comes close: one frame byte at most
  // waits out a short random gap on the sender plus a short random stall on
  // the receiver, and a drain before a register write is short as well.
  localparam int unsigned STALL_LIMIT     = 4000;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned BYTES_PER_PHASE = 115;
  localparam int unsigned REPORT_MAX      = 10;

  // Frame layout as the parser sees it.
  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [3:0] HIGH_POS  = 4'd2;
  localparam logic [3:0] LOW_POS   = 4'd3;
  localparam logic [3:0] CHECK_POS = 4'd8;

  logic        clk;
  logic        rst_n             = 1'b0;
  logic        in_valid          = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte        = 8'h00;
  logic        out_valid;
  logic        out_stall         = 1'b0;
  logic [15:0] out_concentration;
  logic        out_sum_match;
  logic        cfg_wr_en         = 1'b0;
  logic        cfg_index         = REG_COMMAND_CODE;
  logic [7:0]  cfg_wdata         = 8'h00;

  gas_sensor_frame_parser_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_concentration (out_concentration),
    .out_sum_match     (out_sum_match),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Shadow of the parser: registers and frame-tracking state.
  gsfp_cfg_t   ps_cfg;
  gsfp_phase_t ps_phase;
  logic [3:0]  ps_pos;
  logic [7:0]  ps_sum;
  logic [7:0]  ps_high;
  logic [7:0]  ps_low;

  // Result words still owed by the block, oldest first.
  gsfp_res_t   pending_results[$];
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned dead_cycles  = 0;
  // Set to hold both channels free of idling for a whole stretch.
  bit          steady       = 1'b0;

  // Directed opening: one row per byte or register write. Rows that end a
  // frame carry the result word typed in by hand; plain byte rows lean on the
  // predictor (they yield nothing).
  typedef enum logic [1:0] {
    ROW_BYTE,
    ROW_FRAME_END,
    ROW_SET_COMMAND,
    ROW_SET_NIBBLE
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  data;
    logic [15:0] conc;
    logic        ok;
  } row_t;

  localparam int unsigned OPENING_ROWS = 32;
  localparam row_t OPENING [OPENING_ROWS] = '{
    // Reset command 0x86, both value bytes at the top: 0xFFFF, good checksum.
    '{ROW_BYTE,      8'hFF, 16'h0000, 1'b0},
    '{ROW_BYTE,      8'h86, 16'h0000, 1'b0},
    '{ROW_BYTE,      8'hFF, 16'h0000, 1'b0},
    '{ROW_BYTE,      8'hFF, 16'h0000, 1'b0},
    '{ROW_BYTE,      8'h00, 16'h0000, 1'b0},
    '{ROW_BYTE,      8'h00, 16'h0000, 1'b0},
    '{ROW_BYTE,      8'h00, 16'h0000, 1'b0},
    '{ROW_BYTE,      8'h00, 16'h0000, 1'b0},
    '{ROW_FRAME_END, 8'h7C, 16'hFFFF, 1'b1},
    // Wrong command byte that is itself 0xFF: drop back to hunting without
    // taking it as a new start, so the 0x86 after it must be ignored.
    '{ROW_BYTE,      8'hFF, 16'h0000, 1'b0},
    '{ROW_BYTE,      8'hFF, 16'h0000, 1'b0},
    '{ROW_BYTE,      8'h86, 16'h0000, 1'b0},
    // Zero value, checksum off by one: the word still comes, flagged bad.
    '{ROW_BYTE,      8'hFF, 16'h0000, 1'b0},
    '{ROW_BYTE,      8'h86, 16'h0000, 1'b0},
    '{ROW_BYTE,      8'h00, 16'h0000, 1'b0},
    '{ROW_BYTE,      8'h00, 16'h0000, 1'b0},
    '{ROW_BYTE,      8'h01, 16'h0000, 1'b0},
    '{ROW_BYTE,      8'h02, 16'h0000, 1'b0},
    '{ROW_BYTE,      8'h03, 16'h0000, 1'b0},
    '{ROW_BYTE,      8'h04, 16'h0000, 1'b0},
    '{ROW_FRAME_END, 8'h71, 16'h0000, 1'b0},
    // Command 0xFF and nibble conversion on.
    '{ROW_SET_COMMAND, 8'hFF, 16'h0000, 1'b0},
    '{ROW_SET_NIBBLE,  8'h01, 16'h0000, 1'b0},
    // 160 and 255 wrap through the conversion: 0x00 and 0x95.
    '{ROW_BYTE,      8'hFF, 16'h0000, 1'b0},
    '{ROW_BYTE,      8'hFF, 16'h0000, 1'b0},
    '{ROW_BYTE,      8'hA0, 16'h0000, 1'b0},
    '{ROW_BYTE,      8'hFF, 16'h0000, 1'b0},
    '{ROW_BYTE,      8'h00, 16'h0000, 1'b0},
    '{ROW_BYTE,      8'h00, 16'h0000, 1'b0},
    '{ROW_BYTE,      8'h00, 16'h0000, 1'b0},
    '{ROW_BYTE,      8'h00, 16'h0000, 1'b0},
    '{ROW_FRAME_END, 8'h62, 16'h0095, 1'b1}
  };

  // Decimal digits of v packed as two nibbles, wrapped to 8 bits.
  function automatic logic [7:0] to_nibbles(input logic [7:0] v);
    int unsigned digits;
    digits = (v / 10) * 16 + (v % 10);
    return digits[7:0];
  endfunction

  // Advance the shadow parser by one byte; return 1 with the word it yields.
  function automatic bit parse_byte(input logic [7:0] b, output gsfp_res_t res);
    logic [7:0] hi;
    logic [7:0] lo;
    bit         got;
    got = 1'b0;
    res = '0;
    case (ps_phase)
      PH_CMD: begin
        if (b == ps_cfg.command_code) begin
          ps_phase = PH_DATA;
          ps_sum   = b;
          ps_pos   = HIGH_POS;
        end else begin
          ps_phase = PH_HUNT;
          ps_pos   = '0;
        end
      end
      PH_DATA: begin
        if (ps_pos >= CHECK_POS) begin
          hi = ps_cfg.nibble_convert ? to_nibbles(ps_high) : ps_high;
          lo = ps_cfg.nibble_convert ? to_nibbles(ps_low) : ps_low;
          res.concentration = {hi, lo};
          res.sum_match     = (b == 8'(8'h00 - ps_sum));
          ps_phase = PH_HUNT;
          ps_pos   = '0;
          got      = 1'b1;
        end else begin
          if (ps_pos == HIGH_POS) ps_high = b;
          else if (ps_pos == LOW_POS) ps_low = b;
          ps_sum = ps_sum + b;
          ps_pos = ps_pos + 4'd1;
        end
      end
      default: begin
        // Hunting, and any stray phase code behaves the same.
        ps_phase = PH_HUNT;
        ps_pos   = '0;
        if (b == SYNC_BYTE) begin
          ps_phase = PH_CMD;
          ps_pos   = 4'd1;
          ps_sum   = '0;
        end
      end
    endcase
    return got;
  endfunction

  // Value bytes lean toward the edges of the conversion and of the range.
  function automatic logic [7:0] value_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'd159;
      3:       return 8'd160;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offer one byte word after an optional gap, hold it until taken, then
  // predict. A typed word, when given, replaces the predicted one.
  task automatic send_byte(input logic [7:0] b, input bit typed, input gsfp_res_t typed_res);
    gsfp_res_t res;
    bit        got;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    got = parse_byte(b, res);
    if (typed) pending_results.push_back(typed_res);
    else if (got) pending_results.push_back(res);
  endtask

  // Drain the block, let it settle, then write one register.
  task automatic write_register(input logic sel, input logic [7:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (sel == REG_COMMAND_CODE) ps_cfg.command_code = value;
    else ps_cfg.nibble_convert = value[0];
  endtask

  // Send one random sequence: mostly whole frames with random content, the
  // rest cut-off frames, bad command bytes and loose noise.
  task automatic send_sequence(inout int unsigned sent);
    logic [7:0]  frame [9];
    logic [7:0]  sum;
    int unsigned roll;
    int unsigned n;
    roll = $urandom_range(99);
    for (int k = 0; k < 9; k++) frame[k] = 8'($urandom);
    if (roll < 70) begin
      frame[0] = SYNC_BYTE;
      frame[1] = ps_cfg.command_code;
      frame[2] = value_byte();
      frame[3] = value_byte();
      sum = '0;
      for (int k = 1; k < 8; k++) sum = sum + frame[k];
      // Corrupt about one checksum in four.
      if ($urandom_range(3) != 0) frame[8] = 8'h00 - sum;
      n = 9;
    end else if (roll < 85) begin
      frame[0] = SYNC_BYTE;
      if ($urandom_range(1) == 0) frame[1] = ps_cfg.command_code;
      n = $urandom_range(2, 6);
    end else begin
      n = $urandom_range(1, 4);
    end
    for (int k = 0; k < n; k++) begin
      send_byte(frame[k], 1'b0, '0);
      sent++;
    end
  endtask

  // Receiver stall, random unless a steady stretch is running.
  always @(posedge clk) out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);

  // Compare every taken result word with the oldest owed one.
  always @(posedge clk) begin : result_check
    gsfp_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("result word %0d not expected: concentration %h sum_match %b",
                   results_seen, out_concentration, out_sum_match);
      end else begin
        want = pending_results.pop_front();
        if (want.concentration !== out_concentration ||
            want.sum_match !== out_sum_match) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("result word %0d: concentration exp %h got %h, sum_match exp %b got %b",
                     results_seen, want.concentration, out_concentration,
                     want.sum_match, out_sum_match);
        end
      end
    end
  end

  // Watchdog: end the run when no word moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      dead_cycles <= 0;
    end else if (dead_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      dead_cycles <= dead_cycles + 1;
    end
  end

  initial begin
    row_t        r;
    int unsigned sent;
    logic [7:0]  command;
    // Shadow state matches the block after reset.
    ps_cfg.command_code   = COMMAND_CODE_RST;
    ps_cfg.nibble_convert = 1'b0;
    ps_phase = PH_HUNT;
    ps_pos   = '0;
    ps_sum   = '0;
    ps_high  = '0;
    ps_low   = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table.
    for (int i = 0; i < OPENING_ROWS; i++) begin
      r = OPENING[i];
      case (r.kind)
        ROW_SET_COMMAND: write_register(REG_COMMAND_CODE, r.data);
        ROW_SET_NIBBLE:  write_register(REG_NIBBLE_CONVERT, r.data);
        default:         send_byte(r.data, r.kind == ROW_FRAME_END, {r.conc, r.ok});
      endcase
    end

    // Random phases, each under its own register setting. The first three
    // hit the command extremes and the reset value; one phase runs without
    // any idling on either side.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       command = 8'h00;
        1:       command = 8'hFF;
        2:       command = COMMAND_CODE_RST;
        default: command = 8'($urandom);
      endcase
      write_register(REG_COMMAND_CODE, command);
      // Upper bits of the mode register are don't-care; toggle them anyway.
      write_register(REG_NIBBLE_CONVERT, {7'($urandom), 1'(p)});
      steady = (p == 3);
      sent = 0;
      while (sent < BYTES_PER_PHASE) send_sequence(sent);
    end

    // Drop valid, wait for every owed word, then watch for strays.
    in_valid <= 1'b0;
    steady = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
